// ===== sv/arithmetic_range_encoder_top_defines.svh =====
// assertion macros for the arithmetic range encoder
`ifndef ARITHMETIC_RANGE_ENCODER_TOP_DEFINES_SVH
`define ARITHMETIC_RANGE_ENCODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define ARE_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");
`define ARE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ARE_ASSERT(lbl, cond)
`define ARE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== sv/are_pkg.sv =====
// types and constants shared by the range encoder modules
package are_pkg;

    localparam int SYM_LOW_W   = 16;
    localparam int SYM_W       = 17;
    localparam int BYTE_W      = 8;
    localparam int MAX_RESULTS = 36;
    localparam int MEM_AW      = 6;
    localparam int CNT_W       = 6;

    localparam logic [1:0] REN_ZERO = 2'd0;
    localparam logic [1:0] REN_ONE  = 2'd1;
    localparam logic [1:0] REN_MID  = 2'd2;
    localparam logic [1:0] REN_STOP = 2'd3;

    typedef struct packed {
        logic                 command;
        logic [SYM_LOW_W-1:0] sym_low;
        logic [SYM_W-1:0]     sym_high;
        logic [SYM_W-1:0]     total;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              pending_overflow;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul_hi;
        logic mul_lo;
        logic narrow;
        logic ren;
        logic pend;
        logic flush_bit;
        logic flush_tail;
        logic rd_issue;
        logic pop;
    } t_cmd;

    typedef struct packed {
        logic [1:0] ren_kind;
        logic       pend_zero;
        logic       pend_one;
        logic       cnt_zero;
        logic       rd_last;
    } t_sts;

endpackage

// ===== sv/are_ctrl.sv =====
// sequencer for the range encoder
module are_ctrl #(
    parameter int CODE_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_command,
    input  logic          i_stall,
    input  are_pkg::t_sts i_sts,
    output are_pkg::t_cmd o_cmd,
    output logic          o_stall,
    output logic          o_valid
);
    localparam int DCW = $clog2(CODE_WIDTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_MULH  = 4'd2;
    localparam logic [3:0] S_MULL  = 4'd3;
    localparam logic [3:0] S_NAR   = 4'd4;
    localparam logic [3:0] S_REN   = 4'd5;
    localparam logic [3:0] S_PEND  = 4'd6;
    localparam logic [3:0] S_FBIT  = 4'd7;
    localparam logic [3:0] S_FTAIL = 4'd8;
    localparam logic [3:0] S_RD    = 4'd9;
    localparam logic [3:0] S_SHOW  = 4'd10;

    logic [3:0]     r_state, n_state;
    logic [DCW-1:0] r_div, n_div;
    logic           r_flush, n_flush;

    always_comb begin
        n_state = r_state;
        n_div   = r_div;
        n_flush = r_flush;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_flush    = i_command;
                    n_div      = DCW'(CODE_WIDTH);
                    n_state    = i_command ? S_FBIT : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_div == '0) n_state = S_MULH;
                else n_div = r_div - 1'b1;
            end
            S_MULH: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_MULL;
            end
            S_MULL: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_NAR;
            end
            S_NAR: begin
                o_cmd.narrow = 1'b1;
                n_state      = S_REN;
            end
            S_REN: begin
                if (i_sts.ren_kind == are_pkg::REN_STOP) begin
                    n_state = S_RD;
                end else begin
                    o_cmd.ren = 1'b1;
                    if (i_sts.ren_kind != are_pkg::REN_MID && !i_sts.pend_zero)
                        n_state = S_PEND;
                end
            end
            S_PEND: begin
                o_cmd.pend = 1'b1;
                if (i_sts.pend_one) n_state = r_flush ? S_FTAIL : S_REN;
            end
            S_FBIT: begin
                o_cmd.flush_bit = 1'b1;
                n_state         = S_PEND;
            end
            S_FTAIL: begin
                o_cmd.flush_tail = 1'b1;
                n_state          = S_RD;
            end
            S_RD: begin
                if (i_sts.cnt_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_SHOW;
                end
            end
            S_SHOW: begin
                if (!i_stall) begin
                    o_cmd.pop = 1'b1;
                    n_state   = i_sts.rd_last ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_div   <= '0;
            r_flush <= 1'b0;
        end else begin
            r_state <= n_state;
            r_div   <= n_div;
            r_flush <= n_flush;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_SHOW);

endmodule

// ===== sv/are_dp.sv =====
// interval, divider, bit packer and byte store of the range encoder
`include "arithmetic_range_encoder_top_defines.svh"
module are_dp #(
    parameter int CODE_WIDTH    = 32,
    parameter int PENDING_WIDTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  are_pkg::t_in_item i_item,
    input  are_pkg::t_cmd     i_cmd,
    output are_pkg::t_sts     o_sts,
    output are_pkg::t_out_item o_item
);
    localparam int CW  = CODE_WIDTH;
    localparam int W   = CODE_WIDTH + 2;
    localparam int SW  = are_pkg::SYM_W;
    localparam int LW  = are_pkg::SYM_LOW_W;
    localparam int BW  = are_pkg::BYTE_W;
    localparam int NW  = are_pkg::CNT_W;
    localparam logic [CW-1:0] QUARTER = CW'(1) << (CW - 2);
    localparam logic [PENDING_WIDTH-1:0] PEND_MAX = '1;

    logic [CW-1:0]            r_low, n_low, r_high, n_high, r_nh;
    logic [PENDING_WIDTH-1:0] r_pend, n_pend;
    logic [BW-1:0]            r_buf, n_buf;
    logic [3:0]               r_bf, n_bf;
    logic                     r_ovf, n_ovf, r_bit, n_bit;
    logic [LW-1:0]            r_sl;
    logic [SW-1:0]            r_sh, r_tot;
    logic [CW:0]              r_quo;
    logic [SW-1:0]            r_rem;
    logic [W-1:0]             r_prod;
    logic [NW-1:0]            r_cnt, r_rd;
    logic [BW-1:0]            r_q;
    logic                     r_rd_last;
    logic [BW-1:0]            mem [0:(1 << are_pkg::MEM_AW)-1];

    // operand cleanup at load
    logic [SW-1:0] t0, s1, s2;
    logic [LW-1:0] l0;
    always_comb begin
        t0 = (i_item.total == '0) ? SW'(1) : i_item.total;
        s1 = (i_item.sym_high > t0) ? t0 : i_item.sym_high;
        s2 = (s1 == '0) ? SW'(1) : s1;
        l0 = ({1'b0, i_item.sym_low} >= s2) ? LW'(s2 - 1'b1) : i_item.sym_low;
    end

    // one restoring divide step
    logic [SW:0] trial;
    logic        ge;
    always_comb begin
        trial = {r_rem, r_quo[CW]};
        ge    = (trial >= {1'b0, r_tot});
    end

    logic [CW:0]   step;
    logic [W-1:0]  mul_b, sum_h, sum_l;
    logic [W+SW-1:0] prod_full;
    always_comb begin
        step      = (r_quo == '0) ? (CW+1)'(1) : r_quo;
        mul_b     = i_cmd.mul_hi ? W'(r_sh) : W'(r_sl);
        prod_full = (W+SW)'(mul_b) * (W+SW)'(step);
        sum_h     = W'(r_low) + r_prod - W'(1);
        sum_l     = W'(r_low) + r_prod;
    end

    logic [1:0] kind;
    always_comb begin
        if (!r_high[CW-1])                               kind = are_pkg::REN_ZERO;
        else if (r_low[CW-1])                            kind = are_pkg::REN_ONE;
        else if (r_low[CW-2] && !r_high[CW-2])           kind = are_pkg::REN_MID;
        else                                             kind = are_pkg::REN_STOP;
    end

    logic          put, pb, push;
    logic [BW-1:0] put_val, push_data;
    logic [2:0]    idx;

    always_comb begin
        n_low   = r_low;
        n_high  = r_high;
        n_pend  = r_pend;
        n_buf   = r_buf;
        n_bf    = r_bf;
        n_ovf   = r_ovf;
        n_bit   = r_bit;
        put     = 1'b0;
        pb      = 1'b0;
        push    = 1'b0;
        push_data = r_buf;
        if (i_cmd.narrow) begin
            n_high = r_nh;
            n_low  = (sum_l > W'(r_nh)) ? r_nh : CW'(sum_l);
        end
        if (i_cmd.ren) begin
            if (kind == are_pkg::REN_MID) begin
                if (r_pend == PEND_MAX) n_ovf = 1'b1;
                else n_pend = r_pend + 1'b1;
                n_low  = (r_low - QUARTER) << 1;
                n_high = ((r_high - QUARTER) << 1) | CW'(1);
            end else begin
                put    = 1'b1;
                pb     = (kind == are_pkg::REN_ONE);
                n_bit  = pb;
                n_low  = r_low << 1;
                n_high = (r_high << 1) | CW'(1);
            end
        end
        if (i_cmd.flush_bit) begin
            if (r_pend == PEND_MAX) n_ovf = 1'b1;
            else n_pend = r_pend + 1'b1;
            put   = 1'b1;
            pb    = r_low[CW-1] | r_low[CW-2];
            n_bit = pb;
        end
        if (i_cmd.pend) begin
            put    = 1'b1;
            pb     = ~r_bit;
            n_pend = r_pend - 1'b1;
        end
        idx     = 3'(r_bf - 4'd1);
        put_val = r_buf | (BW'(pb) << idx);
        if (put) begin
            if (r_bf == 4'd1) begin
                push      = 1'b1;
                push_data = put_val;
                n_buf     = '0;
                n_bf      = 4'd8;
            end else begin
                n_buf = put_val;
                n_bf  = r_bf - 4'd1;
            end
        end
        if (i_cmd.flush_tail) begin
            push   = (r_buf != '0);
            n_low  = '0;
            n_high = '1;
            n_pend = '0;
            n_buf  = '0;
            n_bf   = 4'd8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '1;
            r_pend <= '0;
            r_buf  <= '0;
            r_bf   <= 4'd8;
            r_ovf  <= 1'b0;
            r_bit  <= 1'b0;
            r_cnt  <= '0;
            r_rd   <= '0;
        end else begin
            r_low  <= n_low;
            r_high <= n_high;
            r_pend <= n_pend;
            r_buf  <= n_buf;
            r_bf   <= n_bf;
            r_ovf  <= n_ovf;
            r_bit  <= n_bit;
            if (i_cmd.load) begin
                r_cnt <= '0;
                r_rd  <= '0;
            end else begin
                if (push && r_cnt < NW'(are_pkg::MAX_RESULTS)) r_cnt <= r_cnt + 1'b1;
                if (i_cmd.pop) r_rd <= r_rd + 1'b1;
            end
        end
    end

    // operands, divider and products
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sl  <= l0;
            r_sh  <= s2;
            r_tot <= t0;
            r_quo <= {1'b0, r_high} - {1'b0, r_low} + (CW+1)'(1);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[CW-1:0], ge};
            r_rem <= ge ? SW'(trial - {1'b0, r_tot}) : SW'(trial);
        end
        if (i_cmd.mul_hi || i_cmd.mul_lo) r_prod <= W'(prod_full);
        if (i_cmd.mul_lo) r_nh <= (sum_h > W'(r_high)) ? r_high : CW'(sum_h);
    end

    // byte store
    always_ff @(posedge i_clk) begin
        if (push && r_cnt < NW'(are_pkg::MAX_RESULTS)) mem[r_cnt] <= push_data;
        if (i_cmd.rd_issue) begin
            r_q       <= mem[r_rd];
            r_rd_last <= (r_rd == r_cnt - 1'b1);
        end
    end

    assign o_sts.ren_kind  = kind;
    assign o_sts.pend_zero = (r_pend == '0);
    assign o_sts.pend_one  = (r_pend == PENDING_WIDTH'(1));
    assign o_sts.cnt_zero  = (r_cnt == '0);
    assign o_sts.rd_last   = r_rd_last;

    assign o_item.out_byte         = r_q;
    assign o_item.last             = r_rd_last;
    assign o_item.pending_overflow = r_ovf;

    `ARE_ASSERT(bits_free_range, (r_bf != 4'd0) && (r_bf <= 4'd8))
    `ARE_ASSERT(interval_ordered, r_low <= r_high)
    `ARE_ASSERT(count_bounded, r_cnt <= NW'(are_pkg::MAX_RESULTS))
    `ARE_ASSERT_NXT(overflow_sticky, r_ovf, r_ovf)

endmodule

// ===== sv/arithmetic_range_encoder_top.sv =====
// top level of the integer arithmetic range encoder
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_item (command, sym_low, sym_high, total)
//  output  | out       | o_valid / i_stall  | o_item (out_byte, last, pending_overflow)
// an encode item is loaded, then runs the divide steps and the high product, low product and
// narrow steps, then each renormalize step, each pending bit and a closing check, then a read
// and a show per output byte; the serial restoring divider takes most of that time
// a flush item emits a flush bit, its pending bits and the partial byte before bytes go out
// reset is synchronous and active low; o_stall stays high until the last byte of an item is taken
// i_stall holds the current byte in place and halts the block
module arithmetic_range_encoder_top #(
    parameter int CODE_WIDTH    = 32,
    parameter int PENDING_WIDTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  are_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output are_pkg::t_out_item o_item
);
    are_pkg::t_cmd cmd;
    are_pkg::t_sts sts;

    are_ctrl #(
        .CODE_WIDTH(CODE_WIDTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_item.command),
        .i_stall   (i_stall),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_stall   (o_stall),
        .o_valid   (o_valid)
    );

    are_dp #(
        .CODE_WIDTH   (CODE_WIDTH),
        .PENDING_WIDTH(PENDING_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_item  (o_item)
    );

endmodule

// ===== bench/arithmetic_range_encoder_top_test.sv =====
// testbench for the arithmetic range encoder: predicts code bytes per item and checks them
module arithmetic_range_encoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;
    localparam longint unsigned CODE_MAX  = 64'hFFFF_FFFF;
    localparam longint unsigned CODE_HALF = 64'h8000_0000;
    localparam longint unsigned CODE_QTR  = 64'h4000_0000;
    localparam longint unsigned CODE_3QTR = 64'hC000_0000;
    localparam int PEND_MAX = 255;
    localparam int CYCLE_LIMIT = 2_000_000;

    class code_byte_board;
        are_pkg::t_out_item byte_q[$];
        int errors;
        int shown;
        longint unsigned lo, hi;
        int pend;
        logic [7:0] acc;
        int free_bits;
        logic ovf;
        are_pkg::t_out_item item_bytes[$];

        function new();
            errors = 0;
            shown = 0;
            ovf = 0;
            init_coder();
        endfunction

        function void init_coder();
            lo = 0;
            hi = CODE_MAX;
            pend = 0;
            acc = 0;
            free_bits = 8;
        endfunction

        function void push_byte(logic [7:0] b);
            are_pkg::t_out_item r;
            r.out_byte = b;
            r.last = 0;
            r.pending_overflow = 0;
            if (item_bytes.size() < are_pkg::MAX_RESULTS)
                item_bytes.insert(item_bytes.size(), r);
        endfunction

        function void put_bit(logic b);
            free_bits--;
            acc[free_bits] = b;
            if (free_bits == 0) begin
                push_byte(acc);
                acc = 0;
                free_bits = 8;
            end
        endfunction

        function void write_bit(logic b);
            put_bit(b);
            while (pend != 0) begin
                put_bit(!b);
                pend--;
            end
        endfunction

        function void bump_pending();
            if (pend < PEND_MAX) pend++;
            else ovf = 1;
        endfunction

        function void note_item(are_pkg::t_in_item it);
            longint unsigned sl, sh, tot, step, nh, nl;
            item_bytes.delete();
            if (it.command == CMD_FLUSH) begin
                bump_pending();
                write_bit(lo < CODE_QTR ? 1'b0 : 1'b1);
                if (acc != 0) push_byte(acc);
                init_coder();
            end else begin
                sl = it.sym_low;
                sh = it.sym_high;
                tot = it.total;
                if (tot == 0) tot = 1;
                if (sh > tot) sh = tot;
                if (sh == 0) sh = 1;
                if (sl >= sh) sl = sh - 1;
                step = (hi - lo + 1) / tot;
                if (step == 0) step = 1;
                nh = lo + sh * step - 1;
                if (nh > hi) nh = hi;
                nl = lo + sl * step;
                if (nl > nh) nl = nh;
                hi = nh & CODE_MAX;
                lo = nl & CODE_MAX;
                forever begin
                    if (hi < CODE_HALF) write_bit(1'b0);
                    else if (lo >= CODE_HALF) write_bit(1'b1);
                    else if (lo >= CODE_QTR && hi < CODE_3QTR) begin
                        bump_pending();
                        lo -= CODE_QTR;
                        hi -= CODE_QTR;
                    end else break;
                    hi = ((hi << 1) | 1) & CODE_MAX;
                    lo = (lo << 1) & CODE_MAX;
                end
            end
            foreach (item_bytes[k]) begin
                item_bytes[k].pending_overflow = ovf;
                item_bytes[k].last = (k == item_bytes.size() - 1);
                byte_q.insert(byte_q.size(), item_bytes[k]);
            end
        endfunction

        function void fail(string what, are_pkg::t_out_item exp_b, are_pkg::t_out_item got);
            errors++;
            if (shown < 10) begin
                shown++;
                $display("mismatch %s: expected byte %02h last %0b ovf %0b, got %02h %0b %0b",
                         what, exp_b.out_byte, exp_b.last, exp_b.pending_overflow,
                         got.out_byte, got.last, got.pending_overflow);
            end
        endfunction

        function void check_byte(are_pkg::t_out_item got);
            are_pkg::t_out_item e;
            if (byte_q.size() == 0) begin
                e = '0;
                fail("unexpected", e, got);
            end else begin
                e = byte_q.pop_front();
                if (got.out_byte !== e.out_byte) fail("out_byte", e, got);
                else if (got.last !== e.last) fail("last", e, got);
                else if (got.pending_overflow !== e.pending_overflow) fail("overflow", e, got);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_stall = 0;
    logic o_stall, o_valid;
    are_pkg::t_in_item i_item = '0;
    are_pkg::t_out_item o_item;
    code_byte_board board = new();
    int cycles = 0;
    int rx_wait = 0;
    bit hold_off = 0;
    bit random_stall = 1;

    always #10 i_clk = ~i_clk;

    arithmetic_range_encoder_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && i_valid && !o_stall) board.note_item(i_item);
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_byte(o_item);
            rx_wait = random_stall ? $urandom_range(0, 5) : 0;
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: waits a drawn number of cycles per byte, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_off || rx_wait > 0) i_stall <= 1;
        else i_stall <= 0;
        if (!hold_off && rx_wait > 0) rx_wait--;
    end

    task automatic send_item(are_pkg::t_in_item it, int gap);
        repeat (gap + 1) @(negedge i_clk);
        i_item <= it;
        i_valid <= 1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        i_valid <= 0;
    endtask

    task automatic drain();
        while (board.byte_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic are_pkg::t_in_item make_encode(int sl, int sh, int tot);
        are_pkg::t_in_item it;
        it.command = CMD_ENCODE;
        it.sym_low = sl[15:0];
        it.sym_high = sh[16:0];
        it.total = tot[16:0];
        return it;
    endfunction

    function automatic are_pkg::t_in_item make_flush();
        are_pkg::t_in_item it;
        it = make_encode($urandom, $urandom, $urandom);
        it.command = CMD_FLUSH;
        return it;
    endfunction

    function automatic are_pkg::t_in_item random_symbol();
        int tot, sh, sl;
        case ($urandom_range(0, 9))
            0: return make_encode($urandom, $urandom, $urandom);
            1: tot = $urandom_range(1, 4);
            2: tot = 65536;
            default: tot = $urandom_range(2, 4096);
        endcase
        sh = $urandom_range(1, tot);
        sl = $urandom_range(0, sh - 1);
        return make_encode(sl, sh, tot);
    endfunction

    initial begin
        int n;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        // directed: extremes and clamp cases
        send_item(make_encode(0, 1, 1), 0);
        send_item(make_encode(0, 1, 65536), 1);
        send_item(make_encode(65535, 65536, 65536), 0);
        send_item(make_encode(0, 0, 0), 2);
        send_item(make_encode(5, 131071, 10), 0);
        send_item(make_encode(9, 3, 10), 0);
        send_item(make_encode(65535, 131071, 131071), 0);
        send_item(make_flush(), 0);
        send_item(make_flush(), 1);
        // middle symbols raise the pending count without emitting bits
        for (int k = 0; k < 12; k++) send_item(make_encode(1, 3, 4), $urandom_range(0, 5));
        send_item(make_encode(0, 1, 2), 0);
        send_item(make_flush(), 0);
        // sender pauses until all bytes are out
        drain();
        // long receiver hold-off while sender keeps offering
        hold_off = 1;
        fork
            begin
                repeat (600) @(posedge i_clk);
                hold_off = 0;
            end
            for (int k = 0; k < 12; k++) send_item(random_symbol(), 0);
        join
        send_item(make_flush(), 0);
        n = 0;
        while (n < 500) begin
            if ($urandom_range(0, 3) == 0) random_stall = ~random_stall;
            repeat ($urandom_range(1, 40)) begin
                if (n < 500) send_item(random_symbol(), $urandom_range(0, 5));
                n++;
            end
            send_item(make_flush(), $urandom_range(0, 5));
            n++;
        end
        drain();
        if (board.errors == 0 && board.byte_q.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/are_pkg.sv
sv/are_ctrl.sv
sv/are_dp.sv
sv/arithmetic_range_encoder_top.sv
bench/arithmetic_range_encoder_top_test.sv
